// ----- sv/brs_pkg.sv -----
package brs_pkg;

   // Configuration register map.
   typedef enum logic [1:0] {
      CSR_ORIGIN_X     = 2'd0,
      CSR_ORIGIN_Y     = 2'd1,
      CSR_IMAGE_WIDTH  = 2'd2,
      CSR_IMAGE_HEIGHT = 2'd3
   } csr_index_type;

   // Request kind carried in req_tuser.
   typedef enum logic {
      MODE_WRITE  = 1'b0,
      MODE_SAMPLE = 1'b1
   } mode_type;

   localparam int CHAN_W   = 8;
   localparam int PIXEL_W  = 3 * CHAN_W;
   localparam int COORD_W  = 24;
   localparam int ORIGIN_W = 16;
   localparam int DIM_W    = 9;
   localparam int REQ_W    = 88;

   // Reset sizes of the placed image.
   localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

endpackage

// ----- sv/brs_ram.sv -----
module brs_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16384,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/bilinear_rgb_sampler.sv -----
// Bilinear RGB sampler.
// The req_ stream carries two kinds of request, told apart by req_tuser. A write
// request stores one 24-bit pixel of the source image; a sample request gives a
// screen coordinate in signed fixed point and yields exactly one rsp_ item: the
// bilinear blend of the four neighboring pixels, or black with rsp_tuser low
// when the coordinate is not strictly inside the placed image. Write requests
// produce no response. The csr_ channel sets the image origin and size; it is
// always ready and must only be used while no request is in flight.
// Samples run through all register stages up to rsp_tvalid. One request can be
// accepted every cycle: each of the five register stages carries its own valid
// bit and stays open while it is empty or its successor moves, so bubbles close
// up and req_tready drops only once the whole pipeline is full behind a stalled
// receiver. Throughput is set by the four pixel banks (row parity by column
// parity), each read once per cycle, so all four neighbors come in one access.
// Pixel writes travel with the samples and reach the banks in request order.
// Reset clears the valid bits and restores origin (0,0) and size 256 x 256.
// Pixel memory is not cleared; reading a never-written pixel gives undefined color.
module bilinear_rgb_sampler #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int FRAC_BITS  = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   // Request channel.
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // From bit 0: pixel_col[7:0], pixel_row[15:8], red_in[23:16], green_in[31:24],
   // blue_in[39:32], sample_x[63:40], sample_y[87:64].
   input  logic [brs_pkg::REQ_W-1:0]   req_tdata,
   // From bit 0: mode (0 writes a pixel, 1 samples).
   input  logic                        req_tuser,
   // Response channel.
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // From bit 0: red[7:0], green[15:8], blue[23:16].
   output logic [brs_pkg::PIXEL_W-1:0] rsp_tdata,
   // From bit 0: inside_res.
   output logic                        rsp_tuser,
   // Configuration write channel.
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  brs_pkg::csr_index_type      csr_index,
   input  logic [15:0]                 csr_data
);

   import brs_pkg::*;

   // Column and row index widths, and half-index widths inside one bank.
   localparam int CW   = (MAX_WIDTH  > 2) ? $clog2(MAX_WIDTH)  : 1;
   localparam int RW   = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
   localparam int IXW  = (CW > RW) ? CW : RW;
   localparam int CHW  = (CW > 1) ? CW - 1 : 1;
   localparam int RHW  = (RW > 1) ? RW - 1 : 1;
   localparam int BAW  = CHW + RHW;
   localparam int BANK_DEPTH = 1 << BAW;
   // Integer screen coordinates, relative fixed-point coordinates, weights.
   localparam int CXW  = 26;
   localparam int IW   = ((25 - FRAC_BITS) > 17 ? (25 - FRAC_BITS) : 17) + 1;
   localparam int RXW  = ((ORIGIN_W + FRAC_BITS) > COORD_W ?
                          (ORIGIN_W + FRAC_BITS) : COORD_W) + 1;
   localparam int WW   = 2 * (FRAC_BITS + 1);
   localparam int PW   = WW + CHAN_W;
   localparam int ACCW = PW + 2;

   localparam logic signed [CXW-1:0] HALF   = CXW'(1 << (FRAC_BITS - 1));
   localparam logic signed [CXW-1:0] S_M1   = CXW'((1 << FRAC_BITS) - 1);
   localparam logic signed [RXW-1:0] RX_ONE = RXW'(1);
   localparam logic [FRAC_BITS:0]    S_ONE  = (FRAC_BITS + 1)'(1 << FRAC_BITS);

   // Division by the fixed-point scale, rounding toward zero.
   function automatic logic signed [CXW-1:0] trunc_fix(input logic signed [CXW-1:0] v);
      logic signed [CXW-1:0] r;
      if (v < 0) begin
         r = (v + S_M1) >>> FRAC_BITS;
      end else begin
         r = v >>> FRAC_BITS;
      end
      return r;
   endfunction

   // Saturate a neighbor index into the range from zero to the last valid index.
   function automatic logic [IXW-1:0] clamp_ix(input logic signed [RXW-1:0] i,
                                               input logic [IXW-1:0] lim_m1);
      logic signed [RXW-1:0] lim_s;
      logic [IXW-1:0]        r;
      lim_s = $signed(RXW'(lim_m1));
      if (i < 0) begin
         r = '0;
      end else if (i > lim_s) begin
         r = lim_m1;
      end else begin
         r = IXW'(i);
      end
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Configuration registers.
   // ------------------------------------------------------------------
   logic signed [ORIGIN_W-1:0] origin_x_ff, origin_y_ff;
   logic [DIM_W-1:0]           width_ff, height_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         width_ff    <= DIM_RESET;
         height_ff   <= DIM_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ORIGIN_X:     origin_x_ff <= csr_data;
            CSR_ORIGIN_Y:     origin_y_ff <= csr_data;
            CSR_IMAGE_WIDTH:  width_ff    <= csr_data[DIM_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff   <= csr_data[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // Last usable column and row: the smaller of the image size and the store
   // size, never below one pixel. The user must change these only while idle; the block does not enforce it.
   logic [13:0]    limx, limy, limx_min, limy_min;
   logic [IXW-1:0] limx_m1, limy_m1;

   always_comb begin
      limx_min = (14'(width_ff)  < 14'(MAX_WIDTH))  ? 14'(width_ff)  : 14'(MAX_WIDTH);
      limy_min = (14'(height_ff) < 14'(MAX_HEIGHT)) ? 14'(height_ff) : 14'(MAX_HEIGHT);
      limx     = (limx_min == '0) ? 14'd1 : limx_min;
      limy     = (limy_min == '0) ? 14'd1 : limy_min;
      limx_m1  = IXW'(limx - 14'd1);
      limy_m1  = IXW'(limy - 14'd1);
   end

   // ------------------------------------------------------------------
   // Stage handshake: each stage loads when it is empty or its contents move on.
   // ------------------------------------------------------------------
   logic v1_ff, v2_ff, v3_ff, v4_ff, rsp_valid_ff;
   logic en1, en2, en3, en4, en_out;

   assign en_out     = !rsp_valid_ff || rsp_tready;
   assign en4        = !v4_ff || en_out;
   assign en3        = !v3_ff || en4;
   assign en2        = !v2_ff || en3;
   assign en1        = !v1_ff || en2;
   assign req_tready = en1;

   logic samp2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= req_tvalid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            // Pixel writes leave the pipeline once they reach the banks.
            v3_ff <= v2_ff && samp2_ff;
         end
         if (en4) begin
            v4_ff <= v3_ff;
         end
         if (en_out) begin
            rsp_valid_ff <= v4_ff;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: integer test coordinates and coordinates relative to the origin.
   // ------------------------------------------------------------------
   logic signed [COORD_W-1:0] bx, by;
   logic signed [CXW-1:0]     bx_ext, by_ext;
   logic signed [IW-1:0]      tx_in, ty_in;
   logic signed [RXW-1:0]     rx_in, ry_in;
   logic                      wok_in;

   logic                      samp1_ff, wok1_ff;
   logic [7:0]                col1_ff, row1_ff;
   logic [PIXEL_W-1:0]        pix1_ff;
   logic signed [IW-1:0]      tx1_ff, ty1_ff;
   logic signed [RXW-1:0]     rx1_ff, ry1_ff;

   always_comb begin
      bx     = req_tdata[63:40];
      by     = req_tdata[87:64];
      bx_ext = CXW'(bx);
      by_ext = CXW'(by);
      // Column truncates toward zero; row adds one half before truncating.
      tx_in  = IW'(trunc_fix(bx_ext));
      ty_in  = IW'(trunc_fix(by_ext + HALF));
      rx_in  = RXW'(bx) - (RXW'(origin_x_ff) <<< FRAC_BITS);
      ry_in  = RXW'(by) - (RXW'(origin_y_ff) <<< FRAC_BITS);
      wok_in = (32'(req_tdata[7:0]) < 32'(MAX_WIDTH)) &&
               (32'(req_tdata[15:8]) < 32'(MAX_HEIGHT));
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         samp1_ff <= (req_tuser == MODE_SAMPLE);
         wok1_ff  <= wok_in;
         col1_ff  <= req_tdata[7:0];
         row1_ff  <= req_tdata[15:8];
         pix1_ff  <= req_tdata[39:16];
         tx1_ff   <= tx_in;
         ty1_ff   <= ty_in;
         rx1_ff   <= rx_in;
         ry1_ff   <= ry_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: inside test, neighbor indices and fractional weights.
   // ------------------------------------------------------------------
   logic signed [IW-1:0]  ox_ext, oy_ext, endx, endy;
   logic signed [RXW-1:0] flx_in, fly_in;
   logic                  in_in;
   logic [CW-1:0]         lx_in, ux_in;
   logic [RW-1:0]         ly_in, uy_in;

   logic                  wok2_ff, in2_ff;
   logic [7:0]            col2_ff, row2_ff;
   logic [PIXEL_W-1:0]    pix2_ff;
   logic [CW-1:0]         lx2_ff, ux2_ff;
   logic [RW-1:0]         ly2_ff, uy2_ff;
   logic [FRAC_BITS-1:0]  fx2_ff, fy2_ff;

   always_comb begin
      ox_ext = IW'(origin_x_ff);
      oy_ext = IW'(origin_y_ff);
      endx   = ox_ext + $signed(IW'(width_ff));
      endy   = oy_ext + $signed(IW'(height_ff));
      in_in  = (tx1_ff > ox_ext) && (tx1_ff < endx) &&
               (ty1_ff > oy_ext) && (ty1_ff < endy);
      flx_in = rx1_ff >>> FRAC_BITS;
      fly_in = ry1_ff >>> FRAC_BITS;
      lx_in  = CW'(clamp_ix(flx_in, limx_m1));
      ux_in  = CW'(clamp_ix(flx_in + RX_ONE, limx_m1));
      ly_in  = RW'(clamp_ix(fly_in, limy_m1));
      uy_in  = RW'(clamp_ix(fly_in + RX_ONE, limy_m1));
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         samp2_ff <= samp1_ff;
         wok2_ff  <= wok1_ff;
         col2_ff  <= col1_ff;
         row2_ff  <= row1_ff;
         pix2_ff  <= pix1_ff;
         in2_ff   <= in_in;
         lx2_ff   <= lx_in;
         ux2_ff   <= ux_in;
         ly2_ff   <= ly_in;
         uy2_ff   <= uy_in;
         fx2_ff   <= rx1_ff[FRAC_BITS-1:0];
         fy2_ff   <= ry1_ff[FRAC_BITS-1:0];
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: bank access and weight products. Bank b holds the pixels whose
   // row parity is b[1] and column parity b[0]; the two columns (and two rows)
   // of a neighborhood differ in parity unless clamped onto one, so each bank
   // serves at most one distinct pixel of the neighborhood.
   // ------------------------------------------------------------------
   logic [CW-1:0]        csel [4];
   logic [RW-1:0]        rsel [4];
   logic [BAW-1:0]       rd_addr [4];
   logic [PIXEL_W-1:0]   rd_data [4];
   logic [3:0]           ram_we;
   logic [BAW-1:0]       wr_addr;
   logic [1:0]           wr_bank;
   logic [FRAC_BITS:0]   ax, ay;
   logic [WW-1:0]        w_in [4];

   logic                 in3_ff;
   logic [3:0]           par3_ff;
   logic [WW-1:0]        w3_ff [4];

   always_comb begin
      for (int b = 0; b < 4; b++) begin
         csel[b]    = (lx2_ff[0] == b[0]) ? lx2_ff : ux2_ff;
         rsel[b]    = (ly2_ff[0] == b[1]) ? ly2_ff : uy2_ff;
         rd_addr[b] = {RHW'(rsel[b] >> 1), CHW'(csel[b] >> 1)};
      end
      wr_bank = {row2_ff[0], col2_ff[0]};
      wr_addr = {RHW'(RW'(row2_ff) >> 1), CHW'(CW'(col2_ff) >> 1)};
      for (int b = 0; b < 4; b++) begin
         ram_we[b] = en3 && v2_ff && !samp2_ff && wok2_ff && (wr_bank == 2'(b));
      end
      ax      = S_ONE - {1'b0, fx2_ff};
      ay      = S_ONE - {1'b0, fy2_ff};
      w_in[0] = WW'(ax) * WW'(ay);
      w_in[1] = WW'(fx2_ff) * WW'(ay);
      w_in[2] = WW'(ax) * WW'(fy2_ff);
      w_in[3] = WW'(fx2_ff) * WW'(fy2_ff);
   end

   for (genvar g = 0; g < 4; g++) begin : g_bank
      brs_ram #(
         .WIDTH (PIXEL_W),
         .DEPTH (BANK_DEPTH)
      ) u_bank (
         .clock   (clock),
         .wr_en   (ram_we[g]),
         .wr_addr (wr_addr),
         .wr_data (pix2_ff),
         .rd_en   (en3),
         .rd_addr (rd_addr[g]),
         .rd_data (rd_data[g])
      );
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         in3_ff  <= in2_ff;
         par3_ff <= {uy2_ff[0], ly2_ff[0], ux2_ff[0], lx2_ff[0]};
         for (int k = 0; k < 4; k++) begin
            w3_ff[k] <= w_in[k];
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: route bank outputs to neighbors and weight each channel.
   // Neighbor order: upper-left, upper-right, lower-left, lower-right.
   // ------------------------------------------------------------------
   logic [1:0]         nb_bank [4];
   logic [PIXEL_W-1:0] nb_pix [4];
   logic [PW-1:0]      prod_in [3][4];
   logic               in4_ff;
   logic [PW-1:0]      prod4_ff [3][4];

   always_comb begin
      nb_bank[0] = {par3_ff[2], par3_ff[0]};
      nb_bank[1] = {par3_ff[2], par3_ff[1]};
      nb_bank[2] = {par3_ff[3], par3_ff[0]};
      nb_bank[3] = {par3_ff[3], par3_ff[1]};
      for (int k = 0; k < 4; k++) begin
         nb_pix[k] = rd_data[nb_bank[k]];
         for (int c = 0; c < 3; c++) begin
            prod_in[c][k] = PW'(nb_pix[k][c*CHAN_W +: CHAN_W]) * PW'(w3_ff[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         in4_ff <= in3_ff;
         for (int c = 0; c < 3; c++) begin
            for (int k = 0; k < 4; k++) begin
               prod4_ff[c][k] <= prod_in[c][k];
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 5: sum, drop the fraction bits (black when outside) and register the response.
   // ------------------------------------------------------------------
   logic [ACCW-1:0]    acc [3];
   logic [PIXEL_W-1:0] rgb_in;
   logic [PIXEL_W-1:0] rsp_data_ff;
   logic               rsp_inside_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         acc[c] = ACCW'(prod4_ff[c][0]) + ACCW'(prod4_ff[c][1]) +
                  ACCW'(prod4_ff[c][2]) + ACCW'(prod4_ff[c][3]);
         rgb_in[c*CHAN_W +: CHAN_W] = in4_ff ? acc[c][2*FRAC_BITS +: CHAN_W] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         rsp_data_ff   <= rgb_in;
         rsp_inside_ff <= in4_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_inside_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   a_black_outside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_inside_ff |-> rsp_data_ff == '0)
      else $error("outside sample answered with a nonzero color");

   a_write_retires: assert property (@(posedge clock) disable iff (reset)
      (|ram_we) |=> !v3_ff)
      else $error("pixel write went on past the banks");

   a_one_bank: assert property (@(posedge clock) disable iff (reset)
      $onehot0(ram_we))
      else $error("pixel write hit more than one bank");

   a_adjacent: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> ((ux2_ff == lx2_ff) || (ux2_ff == lx2_ff + 1'b1)) &&
                ((uy2_ff == ly2_ff) || (uy2_ff == ly2_ff + 1'b1)))
      else $error("neighbor indices are not adjacent");

endmodule

// ----- tb/bilinear_rgb_sampler_tb.sv -----
module bilinear_rgb_sampler_tb;
   import brs_pkg::*;

   // Geometry of the pixel store and the fixed-point format of a coordinate.
   localparam int     IMG_MAX      = 256;
   localparam int     FRAC         = 8;
   localparam longint SCALE        = 64'sd1 << FRAC;
   // Wait after the last response, long enough that a trailing pixel write has surely
   // landed in the store before the registers change.
   localparam int     DRAIN_CYCLES = 12;

   // One request as the generator builds it. Fields that do not matter for the
   // request's kind are still filled with random values.
   typedef struct {
      mode_type    mode;
      logic [7:0]  col;
      logic [7:0]  row;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [23:0] sx;
      logic [23:0] sy;
   } pixel_request_type;

   // Predicted response: the color is packed like rsp_tdata (red in the low byte).
   typedef struct {
      logic [23:0] color;
      logic        in_image;
   } blend_result_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata  = '0;
   logic                 req_tuser  = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [PIXEL_W-1:0]   rsp_tdata;
   logic                 rsp_tuser;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   csr_index_type        csr_index  = CSR_ORIGIN_X;
   logic [15:0]          csr_data   = '0;

   // Requests waiting for the driver, and blends waiting for their response.
   pixel_request_type    request_backlog [$];
   blend_result_type     expected_blends [$];
   pixel_request_type    on_bus;

   // Predictor state: the image as the block should hold it and the register copy
   // that is updated on each accepted register write.
   logic [23:0]          pixel_mem [0:IMG_MAX*IMG_MAX-1];
   logic [15:0]          cfg_ox = '0;
   logic [15:0]          cfg_oy = '0;
   logic [8:0]           cfg_w  = DIM_RESET;
   logic [8:0]           cfg_h  = DIM_RESET;

   // Generator state: the register values the queued requests will meet, and which
   // pixels some queued write has already covered. A sample is only queued once all
   // four of its neighbors are covered by an earlier write, so no undefined pixel is ever read.
   bit                   pixel_planned [0:IMG_MAX*IMG_MAX-1];
   logic [15:0]          plan_ox = '0;
   logic [15:0]          plan_oy = '0;
   logic [8:0]           plan_w  = DIM_RESET;
   logic [8:0]           plan_h  = DIM_RESET;
   int                   planned_items = 0;

   // Idle control. An odds value of N starts a burst with chance 1 in N; 0 means never.
   int                   req_idle_odds = 0;
   int                   rsp_idle_odds = 0;
   int                   req_gap  = 0;
   int                   rsp_stall = 0;
   int                   error_count = 0;

   string                chan_name [3] = '{"red", "green", "blue"};

   bilinear_rgb_sampler dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Neighbor indices saturate at the last column or row of the smaller of the
   // programmed size and the store. A zero size still leaves index 0 usable.
   function automatic int clamp_index(input longint idx, input longint dim);
      longint lim;
      lim = (dim < IMG_MAX) ? dim : IMG_MAX;
      if (lim < 1) lim = 1;
      if (idx < 0) idx = 0;
      if (idx > lim - 1) idx = lim - 1;
      return int'(idx);
   endfunction

   // Inside test and neighbor lookup for one coordinate under a given placement.
   // The column test truncates toward zero; the row test first adds one half, which
   // lets a row just above the top edge pass when the origin is negative.
   function automatic bit locate(input logic [23:0] sx, sy, input logic [15:0] ox, oy,
                                 input logic [8:0] w, h,
                                 output int lx, ux, ly, uy, fx, fy);
      longint bx, by, left, top, tx, ty, rx, ry, flx, fly;
      bit     hit;
      bx   = longint'($signed(sx));
      by   = longint'($signed(sy));
      left = longint'($signed(ox));
      top  = longint'($signed(oy));
      tx   = bx / SCALE;
      ty   = (by + SCALE / 2) / SCALE;
      hit  = (left < tx) && (tx < left + longint'(w)) &&
             (top < ty) && (ty < top + longint'(h));
      lx = 0; ux = 0; ly = 0; uy = 0; fx = 0; fy = 0;
      if (hit) begin
         rx  = bx - left * SCALE;
         ry  = by - top * SCALE;
         flx = rx >>> FRAC;
         fly = ry >>> FRAC;
         fx  = int'(rx - flx * SCALE);
         fy  = int'(ry - fly * SCALE);
         lx  = clamp_index(flx, longint'(w));
         ux  = clamp_index(flx + 1, longint'(w));
         ly  = clamp_index(fly, longint'(h));
         uy  = clamp_index(fly + 1, longint'(h));
      end
      return hit;
   endfunction

   // Expected response of a sample under the current registers and image: each
   // channel is the weighted sum of the four neighbors, weights out of SCALE squared,
   // with the fraction simply dropped.
   function automatic blend_result_type sample_image(input logic [23:0] sx, sy);
      blend_result_type  res;
      int                lx, ux, ly, uy, fx, fy;
      longint unsigned   w00, w01, w10, w11, acc;
      logic [23:0]       p00, p01, p10, p11;
      res.color    = '0;
      res.in_image = 1'b0;
      if (locate(sx, sy, cfg_ox, cfg_oy, cfg_w, cfg_h, lx, ux, ly, uy, fx, fy)) begin
         p00 = pixel_mem[ly * IMG_MAX + lx];
         p01 = pixel_mem[ly * IMG_MAX + ux];
         p10 = pixel_mem[uy * IMG_MAX + lx];
         p11 = pixel_mem[uy * IMG_MAX + ux];
         w00 = longint'(SCALE - fx) * longint'(SCALE - fy);
         w01 = longint'(fx) * longint'(SCALE - fy);
         w10 = longint'(SCALE - fx) * longint'(fy);
         w11 = longint'(fx) * longint'(fy);
         for (int c = 0; c < 3; c++) begin
            acc = p00[8*c +: 8] * w00 + p01[8*c +: 8] * w01 +
                  p10[8*c +: 8] * w10 + p11[8*c +: 8] * w11;
            res.color[8*c +: 8] = acc[2*FRAC +: 8];
         end
         res.in_image = 1'b1;
      end
      return res;
   endfunction

   // Channel levels lean toward the extremes so that saturation of the blend is seen.
   function automatic logic [7:0] pick_level();
      case ($urandom_range(0, 5))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // A coordinate a little around the placed image along one axis. Some land on
   // whole pixels or just either side of the half-pixel point where rows round.
   function automatic logic [23:0] near_coordinate(input logic [15:0] origin,
                                                   input logic [8:0] dim);
      longint v;
      int     span;
      span = (dim == 0) ? 4 : int'(dim);
      v = longint'($signed(origin)) * SCALE
          + longint'($urandom_range(0, (span + 4) * IMG_MAX)) - 2 * SCALE;
      case ($urandom_range(0, 7))
         0:       v = v & ~longint'(SCALE - 1);
         1:       v = (v & ~longint'(SCALE - 1)) | 127;
         2:       v = (v & ~longint'(SCALE - 1)) | 128;
         3:       v = (v & ~longint'(SCALE - 1)) | 255;
         default: ;
      endcase
      if (v > 64'sd8388607) v = 64'sd8388607;
      if (v < -64'sd8388608) v = -64'sd8388608;
      return v[23:0];
   endfunction

   task automatic queue_write(input logic [7:0] col, row, red, green, blue);
      pixel_request_type item;
      item.mode  = MODE_WRITE;
      item.col   = col;
      item.row   = row;
      item.red   = red;
      item.green = green;
      item.blue  = blue;
      item.sx    = 24'($urandom);
      item.sy    = 24'($urandom);
      request_backlog.push_back(item);
      pixel_planned[{row, col}] = 1'b1;
      planned_items++;
   endtask

   task automatic cover_pixel(input int col, row);
      if (!pixel_planned[row * IMG_MAX + col])
         queue_write(8'(col), 8'(row), pick_level(), pick_level(), pick_level());
   endtask

   // Queue a sample, preceded by writes of whichever of its neighbors are still blank.
   task automatic queue_sample(input logic [23:0] sx, sy);
      pixel_request_type item;
      int                lx, ux, ly, uy, fx, fy;
      if (locate(sx, sy, plan_ox, plan_oy, plan_w, plan_h, lx, ux, ly, uy, fx, fy)) begin
         cover_pixel(lx, ly);
         cover_pixel(ux, ly);
         cover_pixel(lx, uy);
         cover_pixel(ux, uy);
      end
      item.mode  = MODE_SAMPLE;
      item.col   = 8'($urandom_range(0, 255));
      item.row   = 8'($urandom_range(0, 255));
      item.red   = 8'($urandom_range(0, 255));
      item.green = 8'($urandom_range(0, 255));
      item.blue  = 8'($urandom_range(0, 255));
      item.sx    = sx;
      item.sy    = sy;
      request_backlog.push_back(item);
      planned_items++;
   endtask

   // Wait until every queued request has been taken and every response has come,
   // then give a trailing pixel write time to reach the store.
   task automatic settle();
      while (request_backlog.size() != 0 || req_tvalid || expected_blends.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [15:0] value);
      case (idx)
         CSR_ORIGIN_X:     plan_ox = value;
         CSR_ORIGIN_Y:     plan_oy = value;
         CSR_IMAGE_WIDTH:  plan_w  = value[8:0];
         CSR_IMAGE_HEIGHT: plan_h  = value[8:0];
         default:          ;
      endcase
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic apply_config(input logic [15:0] ox, oy, input logic [8:0] w, h);
      settle();
      write_csr(CSR_ORIGIN_X, ox);
      write_csr(CSR_ORIGIN_Y, oy);
      write_csr(CSR_IMAGE_WIDTH, {7'd0, w});
      write_csr(CSR_IMAGE_HEIGHT, {7'd0, h});
   endtask

   // Random part of a phase. Most requests are samples near the placed image, whose
   // missing neighbors get written first; the rest are samples anywhere in the
   // coordinate range and stray pixel writes.
   task automatic random_traffic(input int count, input bit calm);
      int target;
      int pick;
      target = planned_items + count;
      if (calm) begin
         req_idle_odds = 0;
         rsp_idle_odds = 0;
      end else begin
         req_idle_odds = (1 << $urandom_range(0, 3)) & ~1;
         rsp_idle_odds = (1 << $urandom_range(0, 3)) & ~1;
      end
      while (planned_items < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 65)
            queue_sample(near_coordinate(plan_ox, plan_w), near_coordinate(plan_oy, plan_h));
         else if (pick < 80)
            queue_sample(24'($urandom), 24'($urandom));
         else
            queue_write(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        pick_level(), pick_level(), pick_level());
      end
   endtask

   // Request driver and predictor. An accepted request updates the predicted image or
   // queues the predicted blend; the next request goes out as soon as the slot frees
   // up, unless an idle burst is running. Register writes are tracked here as well.
   always @(posedge clock) begin
      pixel_request_type head;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (on_bus.mode == MODE_WRITE)
               pixel_mem[{on_bus.row, on_bus.col}] = {on_bus.blue, on_bus.green, on_bus.red};
            else
               expected_blends.push_back(sample_image(on_bus.sx, on_bus.sy));
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap = req_gap - 1;
               req_tvalid <= 1'b0;
            end else if (request_backlog.size() > 0) begin
               head = request_backlog.pop_front();
               on_bus = head;
               req_tdata  <= {head.sy, head.sx, head.blue, head.green, head.red,
                              head.row, head.col};
               req_tuser  <= head.mode;
               req_tvalid <= 1'b1;
               if (req_idle_odds != 0 && $urandom_range(1, req_idle_odds) == 1)
                  req_gap = $urandom_range(1, 6);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ORIGIN_X:     cfg_ox = csr_data;
               CSR_ORIGIN_Y:     cfg_oy = csr_data;
               CSR_IMAGE_WIDTH:  cfg_w  = csr_data[8:0];
               CSR_IMAGE_HEIGHT: cfg_h  = csr_data[8:0];
               default:          ;
            endcase
         end
      end
   end

   // Response monitor and receiver. Each accepted response is checked field by field
   // against the oldest predicted blend; rsp_tready drops in random bursts.
   always @(posedge clock) begin
      blend_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_blends.size() == 0) begin
               $display("%0t: response with no sample outstanding: color %h inside %b",
                        $time, rsp_tdata, rsp_tuser);
               error_count++;
            end else begin
               want = expected_blends.pop_front();
               for (int c = 0; c < 3; c++) begin
                  if (rsp_tdata[8*c +: 8] !== want.color[8*c +: 8]) begin
                     $display("%0t: %s mismatch: expected %0d, actual %0d", $time,
                              chan_name[c], want.color[8*c +: 8], rsp_tdata[8*c +: 8]);
                     error_count++;
                  end
               end
               if (rsp_tuser !== want.in_image) begin
                  $display("%0t: inside flag mismatch: expected %b, actual %b", $time,
                           want.in_image, rsp_tuser);
                  error_count++;
               end
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall = rsp_stall - 1;
            rsp_tready <= 1'b0;
         end else if (rsp_idle_odds != 0 && $urandom_range(1, rsp_idle_odds) == 1) begin
            rsp_stall = $urandom_range(0, 5);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      int waited;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed requests under the reset placement (origin 0,0, 256 x 256).
      // Pixel writes at the corners of the store and at (1,1) with extreme colors.
      queue_write(8'd0, 8'd0, 8'd255, 8'd255, 8'd255);
      queue_write(8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
      queue_write(8'd255, 8'd0, 8'd255, 8'd0, 8'd0);
      queue_write(8'd0, 8'd255, 8'd0, 8'd255, 8'd0);
      queue_write(8'd1, 8'd1, 8'd0, 8'd0, 8'd255);
      // Column 1.0 is the first inside column; 0.99 is still outside.
      queue_sample(24'h000100, 24'h000100);
      queue_sample(24'h0000FF, 24'h000100);
      // Row 0.5 rounds up into the image, row 0.496 does not.
      queue_sample(24'h0001FF, 24'h000080);
      queue_sample(24'h000180, 24'h00007F);
      // Far corner: the upper neighbors clamp to the last column and row.
      queue_sample(24'h00FF00, 24'h00FF7F);
      queue_sample(24'h00FFFF, 24'h00FF80);
      queue_sample(24'h010000, 24'h008000);
      // Extremes of the coordinate range and a slightly negative column.
      queue_sample(24'h7FFFFF, 24'h7FFFFF);
      queue_sample(24'h800000, 24'h800000);
      queue_sample(-24'sd128, 24'h000200);
      req_idle_odds = 4;
      rsp_idle_odds = 4;

      // A negative origin lets the rounded row test accept a row just above the top
      // edge; the lower neighbor row then clamps to row 0.
      apply_config(-16'sd5, -16'sd5, 9'd8, 9'd8);
      queue_sample(-24'sd704, -24'sd1382);
      queue_sample(-24'sd1279, -24'sd1300);
      queue_sample(-24'sd1280, -24'sd1000);
      random_traffic(150, 1'b0);

      apply_config(16'sd3, 16'sd5, 9'd4, 9'd3);
      random_traffic(150, 1'b0);
      // A one-pixel image can hold no coordinate strictly inside.
      apply_config(-16'sd32768, -16'sd32768, 9'd1, 9'd1);
      random_traffic(100, 1'b0);
      apply_config(16'sd32767, -16'sd32768, 9'd256, 9'd256);
      random_traffic(120, 1'b0);
      apply_config(-16'sd32768, -16'sd32768, 9'd256, 9'd256);
      random_traffic(150, 1'b0);
      // Sizes beyond the store: neighbors saturate at the store's last column and row.
      apply_config(-16'sd10, -16'sd7, 9'd511, 9'd300);
      random_traffic(150, 1'b0);
      // A zero width means nothing is inside.
      apply_config(16'sd0, 16'sd0, 9'd0, 9'd5);
      random_traffic(100, 1'b0);
      apply_config(16'sd100, -16'sd200, 9'd2, 9'd256);
      random_traffic(150, 1'b0);
      apply_config(-16'sd1, 16'sd1, 9'd17, 9'd9);
      random_traffic(150, 1'b0);
      repeat (2) begin
         apply_config(16'($urandom_range(0, 80) - 40), 16'($urandom_range(0, 80) - 40),
                      9'($urandom_range(1, 20)), 9'($urandom_range(1, 20)));
         random_traffic(150, 1'b0);
      end
      // The closing phase runs without any idling on either side.
      apply_config(16'($urandom), 16'($urandom),
                   9'($urandom_range(1, 256)), 9'($urandom_range(1, 256)));
      random_traffic(150, 1'b1);

      waited = 0;
      while ((request_backlog.size() != 0 || req_tvalid || expected_blends.size() != 0)
             && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_blends.size() != 0) begin
         $display("%0t: %0d expected response(s) never arrived", $time,
                  expected_blends.size());
         error_count++;
      end
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run of this stimulus.
   initial begin
      #2000000;
      $display("%0t: timeout", $time);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
